/* rtl/core/script_lexer_token_stream_macros.svh */
// Assertion macros for the script lexer token stream block
`ifndef SCRIPT_LEXER_TOKEN_STREAM_MACROS_SVH
`define SCRIPT_LEXER_TOKEN_STREAM_MACROS_SVH
`ifndef SYNTHESIS
`define SLTS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SLTS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define SLTS_ASSERT(label, clk, rst_n, prop, msg)
`define SLTS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

/* rtl/core/slts_pkg.sv */
// ----------------------------------------------------------------------------
// slts_pkg
// Shared types, token kinds and keyword table of the script lexer.
// ----------------------------------------------------------------------------
package slts_pkg;

  localparam int unsigned KeywordChars = 8;
  localparam int unsigned PosMax       = 65535;

  localparam logic [5:0] K_DOT      = 6'd9;
  localparam logic [5:0] K_STRING   = 6'd31;
  localparam logic [5:0] K_NUMBER   = 6'd32;
  localparam logic [5:0] K_IDENT    = 6'd33;
  localparam logic [5:0] K_KW0      = 6'd34;
  localparam logic [5:0] K_ERR_CHAR = 6'd61;
  localparam logic [5:0] K_ERR_STR  = 6'd62;
  localparam logic [5:0] K_EOF      = 6'd63;
  localparam logic [5:0] K_STARSTAR = 6'd19;

  typedef logic [KeywordChars*8-1:0] word_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        last_of_run;
  } token_t;

  // One queued entry: up to three tokens produced by a single byte.
  typedef struct packed {
    logic [1:0] count;
    token_t     t0;
    token_t     t1;
    token_t     t2;
  } bundle_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // Keyword lookup on the stored prefix; bytes beyond len are masked off.
  function automatic logic [5:0] word_kind(input word_t w, input logic [15:0] len);
    word_t      m;
    logic [5:0] k;
    m = w;
    k = K_IDENT;
    for (int i = 0; i < KeywordChars; i++) begin
      if (16'(i) >= len) m[i*8 +: 8] = 8'h00;
    end
    if (len != 16'd0 && len <= 16'(KeywordChars)) begin
      case (m)
        {40'h0, "dna"}:      k = K_KW0 + 6'd0;
        {48'h0, "sa"}:       k = K_KW0 + 6'd1;
        {24'h0, "kaerb"}:    k = K_KW0 + 6'd2;
        {32'h0, "esac"}:     k = K_KW0 + 6'd3;
        {24'h0, "hctac"}:    k = K_KW0 + 6'd4;
        {24'h0, "ssalc"}:    k = K_KW0 + 6'd5;
        "eunitnoc":          k = K_KW0 + 6'd6;
        {8'h0, "tluafed"}:   k = K_KW0 + 6'd7;
        {32'h0, "esle"}:     k = K_KW0 + 6'd8;
        {24'h0, "eslaf"}:    k = K_KW0 + 6'd9;
        {8'h0, "yllanif"}:   k = K_KW0 + 6'd10;
        {40'h0, "rof"}:      k = K_KW0 + 6'd11;
        {40'h0, "nuf"}:      k = K_KW0 + 6'd12;
        {48'h0, "fi"}:       k = K_KW0 + 6'd13;
        {40'h0, "lin"}:      k = K_KW0 + 6'd14;
        {48'h0, "ro"}:       k = K_KW0 + 6'd15;
        {24'h0, "tnirp"}:    k = K_KW0 + 6'd16;
        {16'h0, "nruter"}:   k = K_KW0 + 6'd17;
        {16'h0, "citats"}:   k = K_KW0 + 6'd18;
        {24'h0, "repus"}:    k = K_KW0 + 6'd19;
        {16'h0, "hctiws"}:   k = K_KW0 + 6'd20;
        {32'h0, "siht"}:     k = K_KW0 + 6'd21;
        {24'h0, "worht"}:    k = K_KW0 + 6'd22;
        {32'h0, "eurt"}:     k = K_KW0 + 6'd23;
        {40'h0, "yrt"}:      k = K_KW0 + 6'd24;
        {40'h0, "rav"}:      k = K_KW0 + 6'd25;
        {24'h0, "elihw"}:    k = K_KW0 + 6'd26;
        default:             k = K_IDENT;
      endcase
    end
    return k;
  endfunction

  function automatic logic [5:0] op_kind(input logic [7:0] p, input logic eq);
    logic [5:0] k;
    case (p)
      8'h2d:   k = eq ? 6'd13 : 6'd12;
      8'h2b:   k = eq ? 6'd15 : 6'd14;
      8'h2f:   k = eq ? 6'd17 : 6'd16;
      8'h2a:   k = eq ? 6'd20 : 6'd18;
      8'h25:   k = eq ? 6'd22 : 6'd21;
      8'h21:   k = eq ? 6'd24 : 6'd23;
      8'h3d:   k = eq ? 6'd26 : 6'd25;
      8'h3e:   k = eq ? 6'd28 : 6'd27;
      default: k = eq ? 6'd30 : 6'd29;
    endcase
    return k;
  endfunction

endpackage

/* rtl/core/slts_if.sv */
// ----------------------------------------------------------------------------
// slts_byte_if / slts_token_if
// Valid/ready channels for source bytes and tokens.
// ----------------------------------------------------------------------------
interface slts_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface slts_token_if;
  logic        valid;
  logic        ready;
  logic [5:0]  kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [15:0] line_number;
  logic        last_of_run;
  modport source (output valid, output kind, output token_start, output token_length,
                  output line_number, output last_of_run, input ready);
  modport sink (input valid, input kind, input token_start, input token_length,
                input line_number, input last_of_run, output ready);
endinterface

/* rtl/core/script_lexer_token_stream.sv */
// ----------------------------------------------------------------------------
// script_lexer_token_stream
// Streaming lexer: source bytes in, tokens out.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// in_if    in   ch (8)
// out_if   out  kind (6), token_start, token_length, line_number (16), last_of_run
//
// One byte is taken per cycle while the two-entry token queue has room.
// A byte's token bundle is registered in the queue before it appears on out_if.
// A byte yields up to three tokens; the back end drains one token a cycle,
// so input stalls once both entries are held, while a multi-token byte
// drains or while the receiver holds off.
// Reset is asynchronous, active low; no clearing pass is needed.
// After byte 0 every byte is taken and yields nothing until reset.
// ----------------------------------------------------------------------------
`include "script_lexer_token_stream_macros.svh"
module script_lexer_token_stream import slts_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  slts_byte_if.sink   in_if,
  slts_token_if.source out_if
);

  logic    q_ready, q_push;
  bundle_t q_data;
  token_t  tok;

  slts_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ch_i    (in_if.ch),
    .in_ready_o (in_if.ready),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_data_o   (q_data)
  );

  slts_back u_back (
    .clk_i, .rst_ni,
    .push_i      (q_push),
    .data_i      (q_data),
    .ready_o     (q_ready),
    .out_valid_o (out_if.valid),
    .out_tok_o   (tok),
    .out_ready_i (out_if.ready)
  );

  assign out_if.kind = tok.kind;
  assign out_if.token_start = tok.token_start;
  assign out_if.token_length = tok.token_length;
  assign out_if.line_number = tok.line_number;
  assign out_if.last_of_run = tok.last_of_run;

  `SLTS_ASSERT(a_push_room, clk_i, rst_ni, (q_push |-> q_ready), "push into full queue")
  `SLTS_ASSERT(a_line_nz, clk_i, rst_ni, (out_if.valid |-> out_if.line_number != 16'd0), "line zero")
  `SLTS_ASSERT_NEXT(a_eof_end, clk_i, rst_ni, (q_push && q_data.t0.kind == K_EOF), (!q_push), "token after eof")

endmodule

/* rtl/core/slts_front.sv */
// ----------------------------------------------------------------------------
// slts_front
// Scanner state machine: classifies each byte and builds a token bundle.
// ----------------------------------------------------------------------------
module slts_front import slts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_ch_i,
  output logic       in_ready_o,
  input  logic       q_ready_i,
  output logic       q_push_o,
  output bundle_t    q_data_o
);

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_WORD = 3'd1;
  localparam logic [2:0] M_INT  = 3'd2;
  localparam logic [2:0] M_DOT  = 3'd3;
  localparam logic [2:0] M_FRAC = 3'd4;
  localparam logic [2:0] M_STR  = 3'd5;
  localparam logic [2:0] M_CMT  = 3'd6;
  localparam logic [2:0] M_OP   = 3'd7;

  logic [2:0]  mode_q, mode_d;
  logic [7:0]  pend_q, pend_d;
  word_t       word_q, word_d;
  logic [15:0] pos_q, org_q, org_d, line_q, line_d;
  logic        ended_q, ended_d;

  logic        fire;
  logic [15:0] len;
  logic [5:0]  kinds [3];
  logic [15:0] starts [3];
  logic [15:0] lens [3];
  logic [1:0]  cnt;
  logic        do_begin;
  logic [15:0] dot;

  assign in_ready_o = q_ready_i;
  assign fire = in_valid_i && in_ready_o;
  assign len  = (pos_q >= org_q) ? pos_q - org_q : 16'd0;
  assign dot  = (pos_q > org_q) ? pos_q - 16'd1 : org_q;

  always_comb begin
    mode_d = mode_q;
    pend_d = pend_q;
    word_d = word_q;
    org_d = org_q;
    line_d = line_q;
    ended_d = ended_q;
    cnt = 2'd0;
    do_begin = 1'b0;
    for (int i = 0; i < 3; i++) begin
      kinds[i] = '0;
      starts[i] = '0;
      lens[i] = '0;
    end
    case (mode_q)
      M_WORD: begin
        if (is_alpha(in_ch_i) || is_digit(in_ch_i)) begin
          if (len < 16'(KeywordChars)) word_d[len[2:0]*8 +: 8] = in_ch_i;
        end else begin
          kinds[0] = word_kind(word_q, len); starts[0] = org_q; lens[0] = len;
          cnt = 2'd1; do_begin = 1'b1;
        end
      end
      M_INT: begin
        if (in_ch_i == 8'h2e) begin
          mode_d = M_DOT;
        end else if (!is_digit(in_ch_i)) begin
          kinds[0] = K_NUMBER; starts[0] = org_q; lens[0] = len;
          cnt = 2'd1; do_begin = 1'b1;
        end
      end
      M_DOT: begin
        if (is_digit(in_ch_i)) begin
          mode_d = M_FRAC;
        end else begin
          kinds[0] = K_NUMBER; starts[0] = org_q; lens[0] = dot - org_q;
          kinds[1] = K_DOT; starts[1] = dot; lens[1] = 16'd1;
          cnt = 2'd2; do_begin = 1'b1;
        end
      end
      M_FRAC: begin
        if (!is_digit(in_ch_i)) begin
          kinds[0] = K_NUMBER; starts[0] = org_q; lens[0] = len;
          cnt = 2'd1; do_begin = 1'b1;
        end
      end
      M_STR: begin
        if (in_ch_i == 8'h22) begin
          kinds[0] = K_STRING; starts[0] = org_q;
          lens[0] = (len == 16'hffff) ? len : len + 16'd1;
          cnt = 2'd1; mode_d = M_IDLE;
        end else if (in_ch_i == 8'h00) begin
          kinds[0] = K_ERR_STR; starts[0] = org_q;
          cnt = 2'd1; do_begin = 1'b1;
        end else if (in_ch_i == 8'h0a && line_q != 16'hffff) begin
          line_d = line_q + 16'd1;
        end
      end
      M_CMT: begin
        if (in_ch_i == 8'h0a) begin
          if (line_q != 16'hffff) line_d = line_q + 16'd1;
          mode_d = M_IDLE;
        end else if (in_ch_i == 8'h00) begin
          do_begin = 1'b1;
        end
      end
      M_OP: begin
        if (pend_q == 8'h2f && in_ch_i == 8'h2f) begin
          mode_d = M_CMT;
        end else if (pend_q == 8'h2a && in_ch_i == 8'h2a) begin
          kinds[0] = K_STARSTAR; starts[0] = org_q;
          lens[0] = (len == 16'hffff) ? len : len + 16'd1;
          cnt = 2'd1; mode_d = M_IDLE;
        end else if (in_ch_i == 8'h3d) begin
          kinds[0] = op_kind(pend_q, 1'b1); starts[0] = org_q;
          lens[0] = (len == 16'hffff) ? len : len + 16'd1;
          cnt = 2'd1; mode_d = M_IDLE;
        end else begin
          kinds[0] = op_kind(pend_q, 1'b0); starts[0] = org_q; lens[0] = 16'd1;
          cnt = 2'd1; do_begin = 1'b1;
        end
      end
      default: do_begin = 1'b1;
    endcase

    // start of a new token from the current byte
    if (do_begin) begin
      mode_d = M_IDLE;
      kinds[cnt] = '0; starts[cnt] = pos_q; lens[cnt] = 16'd1;
      case (in_ch_i)
        8'h00: begin
          kinds[cnt] = K_EOF; lens[cnt] = 16'd0; ended_d = 1'b1; cnt = cnt + 2'd1;
        end
        8'h20, 8'h0d, 8'h09: ;
        8'h0a: if (line_d != 16'hffff) line_d = line_d + 16'd1;
        8'h28: begin kinds[cnt] = 6'd0;  cnt = cnt + 2'd1; end
        8'h29: begin kinds[cnt] = 6'd1;  cnt = cnt + 2'd1; end
        8'h7b: begin kinds[cnt] = 6'd2;  cnt = cnt + 2'd1; end
        8'h7d: begin kinds[cnt] = 6'd3;  cnt = cnt + 2'd1; end
        8'h5b: begin kinds[cnt] = 6'd4;  cnt = cnt + 2'd1; end
        8'h5d: begin kinds[cnt] = 6'd5;  cnt = cnt + 2'd1; end
        8'h3b: begin kinds[cnt] = 6'd6;  cnt = cnt + 2'd1; end
        8'h2c: begin kinds[cnt] = 6'd7;  cnt = cnt + 2'd1; end
        8'h3a: begin kinds[cnt] = 6'd8;  cnt = cnt + 2'd1; end
        8'h2e: begin kinds[cnt] = K_DOT; cnt = cnt + 2'd1; end
        8'h3f: begin kinds[cnt] = 6'd10; cnt = cnt + 2'd1; end
        8'h7c: begin kinds[cnt] = 6'd11; cnt = cnt + 2'd1; end
        8'h2d, 8'h2b, 8'h2f, 8'h2a, 8'h25, 8'h21, 8'h3d, 8'h3e, 8'h3c: begin
          mode_d = M_OP; pend_d = in_ch_i; org_d = pos_q;
        end
        8'h22: begin mode_d = M_STR; org_d = pos_q; end
        default: begin
          if (is_alpha(in_ch_i)) begin
            mode_d = M_WORD; org_d = pos_q; word_d[7:0] = in_ch_i;
          end else if (is_digit(in_ch_i)) begin
            mode_d = M_INT; org_d = pos_q;
          end else begin
            kinds[cnt] = K_ERR_CHAR; lens[cnt] = 16'd0; cnt = cnt + 2'd1;
          end
        end
      endcase
    end
  end

  // Tokens carry the line count before this byte: a newline never emits a
  // token itself, it only closes the tokens that come before it outside a string.
  always_comb begin
    q_push_o = fire && !ended_q && cnt != 2'd0;
    q_data_o.count = cnt;
    q_data_o.t0 = '{kinds[0], starts[0], lens[0], line_q, cnt == 2'd1};
    q_data_o.t1 = '{kinds[1], starts[1], lens[1], line_q, cnt == 2'd2};
    q_data_o.t2 = '{kinds[2], starts[2], lens[2], line_q, 1'b1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      pend_q <= '0;
      pos_q <= '0;
      org_q <= '0;
      line_q <= 16'd1;
      ended_q <= 1'b0;
    end else if (fire && !ended_q) begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      org_q <= org_d;
      line_q <= line_d;
      ended_q <= ended_d;
      if (pos_q != 16'(PosMax)) pos_q <= pos_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && !ended_q) word_q <= word_d;
  end

endmodule

/* rtl/core/slts_back.sv */
// ----------------------------------------------------------------------------
// slts_back
// Two-entry bundle queue; serializer hands out one token per cycle when ready.
// ----------------------------------------------------------------------------
module slts_back import slts_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t data_i,
  output logic    ready_o,
  output logic    out_valid_o,
  output token_t  out_tok_o,
  input  logic    out_ready_i
);

  bundle_t    mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] fill_q;
  logic [1:0] idx_q;
  logic       pop, last;
  bundle_t    head;

  assign head = mem_q[rptr_q];
  assign out_valid_o = fill_q != 2'd0;
  always_comb begin
    case (idx_q)
      2'd0:    out_tok_o = head.t0;
      2'd1:    out_tok_o = head.t1;
      default: out_tok_o = head.t2;
    endcase
  end
  assign last = (idx_q + 2'd1) == head.count;
  assign pop = out_valid_o && out_ready_i && last;
  assign ready_o = fill_q != 2'd2;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= '0;
      idx_q <= '0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (out_valid_o && out_ready_i) begin
        // advance within the bundle, drop it after its last token
        if (last) begin
          idx_q <= '0;
          rptr_q <= ~rptr_q;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
      fill_q <= fill_q + 2'(push_i) - 2'(pop);
    end
  end

endmodule
